@@ rtl/core/sba_pkg.sv @@
// ----------------------------------------------------------------------------
// sba_pkg
// Shared types and codes for the stream buffer allocator.
// ----------------------------------------------------------------------------
package sba_pkg;

  // fixed field widths
  localparam int ADDR_BITS = 24;
  localparam int SLOT_BITS = 6;

  // slot count and block alignment (alignment is a power of two)
  localparam int SLOT_COUNT  = 64;
  localparam int ALIGN_BYTES = 32;

  // mode codes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAIL   = 2'd1;
  localparam logic [1:0] ST_UNUSED = 2'd2;

  // configuration register indexes
  localparam logic REG_TOP   = 1'b0;
  localparam logic REG_FLOOR = 1'b1;

  typedef struct packed {
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] req_size;
    logic [SLOT_BITS-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [SLOT_BITS-1:0] slot_out;
    logic [ADDR_BITS-1:0] base_addr;
    logic [ADDR_BITS-1:0] used_length;
  } rsp_t;

  // one entry of the slot data memory
  typedef struct packed {
    logic [ADDR_BITS-1:0] base;
    logic [ADDR_BITS-1:0] cap;
    logic [ADDR_BITS-1:0] len;
  } slot_data_t;

  // rounding unit status
  typedef struct packed {
    logic                 done;
    logic [ADDR_BITS:0]   aligned;
  } align_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_AWALK,
    S_AUNLINK,
    S_APUSH,
    S_CARVE_RD,
    S_CARVE,
    S_FWALK,
    S_FUNLINK,
    S_FPUSH,
    S_MWALK,
    S_CWALK,
    S_CFIX,
    S_QUERY,
    S_EMIT
  } sba_state_t;

endpackage

@@ rtl/core/sba_ram.sv @@
// ----------------------------------------------------------------------------
// sba_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sba_align.sv @@
// ----------------------------------------------------------------------------
// sba_align
// Rounds a byte size up to a multiple of ALIGN_BYTES with an add and a mask;
// the result is registered and ready in the cycle after start.
// ----------------------------------------------------------------------------
module sba_align (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sba_pkg::ADDR_BITS-1:0] req_size,
  output sba_pkg::align_stat_t         stat
);
  import sba_pkg::*;

  localparam logic [ADDR_BITS:0] AMASK = (ADDR_BITS+1)'(ALIGN_BYTES - 1);

  // one extra bit keeps sizes near the top of the range from wrapping
  always_ff @(posedge clk) begin
    if (rst) begin
      stat.done <= 1'b0;
    end else begin
      stat.done <= start;
    end
    if (start) begin
      stat.aligned <= ({1'b0, req_size} + AMASK) & ~AMASK;
    end
  end

endmodule

@@ rtl/core/stream_buffer_allocator.sv @@
// ----------------------------------------------------------------------------
// stream_buffer_allocator
// Best-fit slot allocator over a downward growing memory region.
// ----------------------------------------------------------------------------
// Request channel (req_valid / req_stall / req) carries one command word:
// allocate, free, query or no-op. Response channel (rsp_valid / rsp_stall /
// rsp) returns one status word per command. The block handles one command at
// a time; req_stall is high while a command is in progress.
// Slot state sits in two RAMs (slot data, list links); the freed and in-use
// lists are walked one node per cycle through the link RAM.
// A query reads the slot data; mode 3 or a bad index goes straight to the
// response. An allocate rounds the size, then takes the best fit from the
// freed list or else carves a new block below the bottom. A free walks the
// in-use list to its slot; freeing the bottom block adds one pass over the
// in-use list and one over the freed list.
// The response sits in an output register; the next command is taken while
// it waits. A stalled response holds and stops the block in its last state.
// Reset (synchronous) puts all slots in the pool, empties the other lists and
// sets the bottom to region_top. Link RAM entries read as their reset value
// until first written. Configuration writes do not move the bottom.
// ----------------------------------------------------------------------------
module stream_buffer_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  sba_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output sba_pkg::rsp_t                 rsp,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [sba_pkg::ADDR_BITS-1:0] cfg_data
);
  import sba_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int LW = $clog2(SLOT_COUNT + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOT_COUNT);
  localparam int DWID = $bits(slot_data_t);

  sba_state_t state, state_next;

  // walker and list registers
  logic [LW-1:0] node, node_next, prev, prev_next;
  logic          pend, pend_next;
  logic [LW-1:0] best, best_next, best_prev, best_prev_next;
  logic [LW-1:0] best_link, best_link_next;
  logic [ADDR_BITS-1:0] best_base, best_base_next;
  logic [ADDR_BITS:0]   best_cap, best_cap_next;
  logic [LW-1:0] idx, idx_next;
  logic          have, have_next, dirty, dirty_next;
  logic [ADDR_BITS-1:0] mn, mn_next;
  logic [LW-1:0] pool_head, pool_head_next;
  logic [LW-1:0] freed_head, freed_head_next;
  logic [LW-1:0] inuse_head, inuse_head_next;
  logic [ADDR_BITS-1:0] bottom, bottom_next;
  logic [ADDR_BITS-1:0] region_top, region_floor;
  rsp_t          res, res_next;

  // memory ports
  logic            rd_en;
  logic [IW-1:0]   rd_addr;
  logic            lw_en;
  logic [IW-1:0]   lw_addr;
  logic [LW-1:0]   lw_data;
  logic            dw_en;
  slot_data_t      dw_data;
  logic [LW-1:0]   link_rdata;
  logic [DWID-1:0] data_rdata;
  slot_data_t      rd;
  logic [SLOT_COUNT-1:0] lvalid;
  logic            lval_q;
  logic [LW-1:0]   lnk;

  // rounding unit
  logic        align_start;
  align_stat_t align;

  logic               idx_ok;
  logic [ADDR_BITS:0] carve_diff;
  logic               fits;
  logic [ADDR_BITS:0] cap_x;

  sba_align u_align (
    .clk      (clk),
    .rst      (rst),
    .start    (align_start),
    .req_size (req.req_size),
    .stat     (align)
  );

  sba_ram #(.WIDTH(LW), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  sba_ram #(.WIDTH(DWID), .DEPTH(SLOT_COUNT)) u_data_ram (
    .clk   (clk),
    .we    (dw_en),
    .waddr (lw_addr),
    .wdata (dw_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (data_rdata)
  );

  // read data of the node fetched last cycle; unwritten links point to i+1
  assign rd  = slot_data_t'(data_rdata);
  assign lnk = lval_q ? link_rdata : node + LW'(1);

  assign idx_ok     = int'(req.slot_index) < SLOT_COUNT;
  assign carve_diff = {1'b0, bottom} - align.aligned;
  assign fits       = (align.aligned <= {1'b0, bottom}) &&
                      (carve_diff[ADDR_BITS-1:0] >= region_floor);
  assign cap_x      = {1'b0, rd.cap};
  assign req_stall  = (state != S_IDLE);

  // next state, walker steps and memory controls
  always_comb begin
    state_next      = state;
    node_next       = node;
    prev_next       = prev;
    pend_next       = pend;
    best_next       = best;
    best_prev_next  = best_prev;
    best_link_next  = best_link;
    best_base_next  = best_base;
    best_cap_next   = best_cap;
    idx_next        = idx;
    have_next       = have;
    dirty_next      = dirty;
    mn_next         = mn;
    pool_head_next  = pool_head;
    freed_head_next = freed_head;
    inuse_head_next = inuse_head;
    bottom_next     = bottom;
    res_next        = res;
    rd_en           = 1'b0;
    rd_addr         = node[IW-1:0];
    lw_en           = 1'b0;
    lw_addr         = node[IW-1:0];
    lw_data         = NIL;
    dw_en           = 1'b0;
    dw_data         = '0;
    align_start     = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          res_next = '{ST_OK, req.slot_index, '0, '0};
          idx_next = LW'(req.slot_index);
          case (req.mode)
            MODE_ALLOC: begin
              align_start = 1'b1;
              state_next  = S_ALIGN;
            end
            MODE_FREE: begin
              if (idx_ok) begin
                node_next  = inuse_head;
                prev_next  = NIL;
                pend_next  = 1'b0;
                state_next = S_FWALK;
              end else begin
                res_next.status = ST_UNUSED;
                state_next      = S_EMIT;
              end
            end
            MODE_QUERY: begin
              if (idx_ok) begin
                rd_en      = 1'b1;
                rd_addr    = IW'(req.slot_index);
                state_next = S_QUERY;
              end else begin
                res_next.status = ST_UNUSED;
                state_next      = S_EMIT;
              end
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end

      S_ALIGN: begin
        if (align.done) begin
          node_next     = freed_head;
          prev_next     = NIL;
          pend_next     = 1'b0;
          best_next     = NIL;
          best_cap_next = '1;
          state_next    = S_AWALK;
        end
      end

      // best-fit search over the freed list
      S_AWALK: begin
        if (!pend) begin
          if (node == NIL) begin
            state_next = (best != NIL) ? S_AUNLINK : S_CARVE_RD;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = node[IW-1:0];
            pend_next = 1'b1;
          end
        end else if (cap_x == align.aligned) begin
          best_next      = node;
          best_prev_next = prev;
          best_link_next = lnk;
          best_base_next = rd.base;
          best_cap_next  = cap_x;
          pend_next      = 1'b0;
          state_next     = S_AUNLINK;
        end else begin
          if (cap_x > align.aligned && cap_x < best_cap) begin
            best_next      = node;
            best_prev_next = prev;
            best_link_next = lnk;
            best_base_next = rd.base;
            best_cap_next  = cap_x;
          end
          prev_next = node;
          node_next = lnk;
          if (lnk != NIL) begin
            rd_en   = 1'b1;
            rd_addr = lnk[IW-1:0];
          end else begin
            pend_next = 1'b0;
          end
        end
      end

      S_AUNLINK: begin
        if (best_prev == NIL) begin
          freed_head_next = best_link;
        end else begin
          lw_en   = 1'b1;
          lw_addr = best_prev[IW-1:0];
          lw_data = best_link;
        end
        state_next = S_APUSH;
      end

      S_APUSH: begin
        lw_en           = 1'b1;
        lw_addr         = best[IW-1:0];
        lw_data         = inuse_head;
        inuse_head_next = best;
        dw_en           = 1'b1;
        dw_data         = '{best_base, best_cap[ADDR_BITS-1:0],
                            align.aligned[ADDR_BITS-1:0]};
        res_next        = '{ST_OK, SLOT_BITS'(best), best_base,
                            align.aligned[ADDR_BITS-1:0]};
        state_next      = S_EMIT;
      end

      // new block below the bottom, slot taken from the pool
      S_CARVE_RD: begin
        if (pool_head != NIL && fits) begin
          rd_en      = 1'b1;
          rd_addr    = pool_head[IW-1:0];
          node_next  = pool_head;
          state_next = S_CARVE;
        end else begin
          res_next   = '{ST_FAIL, '0, '0, '0};
          state_next = S_EMIT;
        end
      end

      S_CARVE: begin
        pool_head_next  = lnk;
        dw_en           = 1'b1;
        dw_data         = '{carve_diff[ADDR_BITS-1:0], align.aligned[ADDR_BITS-1:0],
                            align.aligned[ADDR_BITS-1:0]};
        lw_en           = 1'b1;
        lw_data         = inuse_head;
        inuse_head_next = node;
        bottom_next     = carve_diff[ADDR_BITS-1:0];
        res_next        = '{ST_OK, SLOT_BITS'(node), carve_diff[ADDR_BITS-1:0],
                            align.aligned[ADDR_BITS-1:0]};
        state_next      = S_EMIT;
      end

      // search the in-use list for the slot being freed
      S_FWALK: begin
        if (!pend) begin
          if (node == NIL) begin
            res_next.status = ST_UNUSED;
            state_next      = S_EMIT;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = node[IW-1:0];
            pend_next = 1'b1;
          end
        end else if (node == idx) begin
          best_link_next       = lnk;
          res_next.base_addr   = rd.base;
          res_next.used_length = rd.len;
          pend_next            = 1'b0;
          state_next           = S_FUNLINK;
        end else begin
          prev_next = node;
          node_next = lnk;
          if (lnk != NIL) begin
            rd_en   = 1'b1;
            rd_addr = lnk[IW-1:0];
          end else begin
            pend_next = 1'b0;
          end
        end
      end

      S_FUNLINK: begin
        if (prev == NIL) begin
          inuse_head_next = best_link;
        end else begin
          lw_en   = 1'b1;
          lw_addr = prev[IW-1:0];
          lw_data = best_link;
        end
        state_next = S_FPUSH;
      end

      // bottom block goes to the pool, any other to the freed list
      S_FPUSH: begin
        lw_en   = 1'b1;
        lw_addr = idx[IW-1:0];
        if (res.base_addr == bottom) begin
          lw_data        = pool_head;
          pool_head_next = idx;
          node_next      = inuse_head;
          pend_next      = 1'b0;
          have_next      = 1'b0;
          state_next     = S_MWALK;
        end else begin
          lw_data         = freed_head;
          freed_head_next = idx;
          state_next      = S_EMIT;
        end
      end

      // lowest base still in use
      S_MWALK: begin
        if (!pend) begin
          if (node == NIL) begin
            node_next  = freed_head;
            prev_next  = NIL;
            dirty_next = 1'b0;
            state_next = S_CWALK;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = node[IW-1:0];
            pend_next = 1'b1;
          end
        end else begin
          if (!have || rd.base < mn) begin
            mn_next   = rd.base;
            have_next = 1'b1;
          end
          node_next = lnk;
          if (lnk != NIL) begin
            rd_en   = 1'b1;
            rd_addr = lnk[IW-1:0];
          end else begin
            pend_next = 1'b0;
          end
        end
      end

      // reclaim freed blocks below the new bottom; the kept predecessor
      // is relinked once the next kept node (or the end) shows up
      S_CWALK: begin
        if (!pend) begin
          if (node == NIL) begin
            state_next = S_CFIX;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = node[IW-1:0];
            pend_next = 1'b1;
          end
        end else begin
          if (!have || rd.base < mn) begin
            lw_en          = 1'b1;
            lw_data        = pool_head;
            pool_head_next = node;
            dirty_next     = 1'b1;
          end else begin
            if (dirty) begin
              if (prev == NIL) begin
                freed_head_next = node;
              end else begin
                lw_en   = 1'b1;
                lw_addr = prev[IW-1:0];
                lw_data = node;
              end
            end
            dirty_next = 1'b0;
            prev_next  = node;
          end
          node_next = lnk;
          if (lnk != NIL) begin
            rd_en   = 1'b1;
            rd_addr = lnk[IW-1:0];
          end else begin
            pend_next = 1'b0;
          end
        end
      end

      S_CFIX: begin
        if (dirty) begin
          if (prev == NIL) begin
            freed_head_next = NIL;
          end else begin
            lw_en   = 1'b1;
            lw_addr = prev[IW-1:0];
            lw_data = NIL;
          end
        end
        bottom_next = have ? mn : region_top;
        state_next  = S_EMIT;
      end

      S_QUERY: begin
        res_next.base_addr   = rd.base;
        res_next.used_length = rd.len;
        state_next           = S_EMIT;
      end

      S_EMIT: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend       <= 1'b0;
      pool_head  <= '0;
      freed_head <= NIL;
      inuse_head <= NIL;
      bottom     <= {ADDR_BITS{1'b1}};
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      pool_head  <= pool_head_next;
      freed_head <= freed_head_next;
      inuse_head <= inuse_head_next;
      bottom     <= bottom_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    node      <= node_next;
    prev      <= prev_next;
    best      <= best_next;
    best_prev <= best_prev_next;
    best_link <= best_link_next;
    best_base <= best_base_next;
    best_cap  <= best_cap_next;
    idx       <= idx_next;
    have      <= have_next;
    dirty     <= dirty_next;
    mn        <= mn_next;
    res       <= res_next;
  end

  // link valid bits and the sampled valid of the fetched node
  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
    end else if (lw_en) begin
      lvalid[lw_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      lval_q <= lvalid[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_top   <= {ADDR_BITS{1'b1}};
      region_floor <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOP) begin
        region_top <= cfg_data;
      end else if (cfg_index == REG_FLOOR) begin
        region_floor <= cfg_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_EMIT && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!rsp_valid || !rsp_stall)) begin
      rsp <= res;
    end
  end

  // walker only waits on a real node
  a_pend_node: assert property (@(posedge clk) disable iff (rst)
    pend |-> node != NIL)
    else $error("walker pending on null node");

  // no link read and write of the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (lw_en && rd_en) |-> lw_addr != rd_addr)
    else $error("link RAM read and write collide");

  // an emitted word lands in the output register
  a_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !rsp_stall) |=> rsp_valid)
    else $error("response word lost");

endmodule

@@ tb/tb_stream_buffer_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_stream_buffer_allocator
// Self-checking bench for the stream buffer allocator. A behavioral copy of
// the slot lists (pool, freed, in-use) predicts every response word. A short
// table of directed commands comes first. Random phases follow, each with its
// own region top and floor. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stream_buffer_allocator;
  import sba_pkg::*;

  localparam int NSLOT = 64;
  localparam int NIL   = 64;
  localparam int LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b1;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_TOP;
  logic [ADDR_BITS-1:0] cfg_data = '0;

  stream_buffer_allocator dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted allocator state
  logic [ADDR_BITS-1:0] p_base [NSLOT];
  logic [ADDR_BITS-1:0] p_cap  [NSLOT];
  logic [ADDR_BITS-1:0] p_len  [NSLOT];
  int                   p_link [NSLOT];
  bit                   p_written [NSLOT];
  bit                   p_busy [NSLOT];
  int pool_hd, freed_hd, inuse_hd;
  logic [ADDR_BITS-1:0] bottom, top_reg, floor_reg;

  rsp_t pending_rsp [$];
  int   fails = 0;
  int   idle_cycles = 0;
  bit   quiet = 1'b0;

  function automatic void predictor_reset();
    for (int i = 0; i < NSLOT; i++) begin
      p_base[i] = '0; p_cap[i] = '0; p_len[i] = '0;
      p_link[i] = i + 1; p_written[i] = 0; p_busy[i] = 0;
    end
    pool_hd = 0; freed_hd = NIL; inuse_hd = NIL;
    top_reg = 24'hFFFFFF; floor_reg = '0; bottom = top_reg;
  endfunction

  function automatic rsp_t mk_rsp(logic [1:0] st, logic [5:0] s,
                                  logic [ADDR_BITS-1:0] b, logic [ADDR_BITS-1:0] l);
    rsp_t r;
    r.status = st; r.slot_out = s; r.base_addr = b; r.used_length = l;
    return r;
  endfunction

  // best fit from the freed list, else carve below the bottom
  function automatic rsp_t predict_alloc(logic [ADDR_BITS-1:0] sz);
    logic [ADDR_BITS:0] al;
    logic [ADDR_BITS+1:0] bcap;
    int n, prv, best, bprev, s;
    al = ({1'b0, sz} + 25'h1F) & ~25'h1F;
    n = freed_hd; prv = NIL; best = NIL; bprev = NIL; bcap = '1;
    while (n != NIL) begin
      if ({1'b0, p_cap[n]} == al) begin
        best = n; bprev = prv;
        break;
      end
      if ({1'b0, p_cap[n]} > al && p_cap[n] < bcap) begin
        best = n; bprev = prv; bcap = p_cap[n];
      end
      prv = n; n = p_link[n];
    end
    if (best != NIL) begin
      if (bprev == NIL) freed_hd = p_link[best];
      else p_link[bprev] = p_link[best];
      p_len[best] = al[ADDR_BITS-1:0];
      p_link[best] = inuse_hd; inuse_hd = best; p_busy[best] = 1;
      return mk_rsp(ST_OK, 6'(best), p_base[best], p_len[best]);
    end
    if (pool_hd != NIL && al <= {1'b0, bottom} && ({1'b0, bottom} - al) >= {1'b0, floor_reg}) begin
      s = pool_hd; pool_hd = p_link[s];
      p_cap[s] = al[ADDR_BITS-1:0]; p_len[s] = al[ADDR_BITS-1:0];
      bottom = bottom - al[ADDR_BITS-1:0];
      p_base[s] = bottom; p_written[s] = 1; p_busy[s] = 1;
      p_link[s] = inuse_hd; inuse_hd = s;
      return mk_rsp(ST_OK, 6'(s), p_base[s], p_len[s]);
    end
    return mk_rsp(ST_FAIL, '0, '0, '0);
  endfunction

  // free; releasing the bottom block raises the bottom and reclaims below it
  function automatic rsp_t predict_free(logic [5:0] idx);
    int n, prv, s, nx;
    bit have;
    logic [ADDR_BITS-1:0] mn;
    rsp_t r;
    n = inuse_hd; prv = NIL;
    while (n != NIL && n != idx) begin
      prv = n; n = p_link[n];
    end
    if (n == NIL) return mk_rsp(ST_UNUSED, idx, '0, '0);
    if (prv == NIL) inuse_hd = p_link[n];
    else p_link[prv] = p_link[n];
    p_busy[n] = 0;
    r = mk_rsp(ST_OK, idx, p_base[n], p_len[n]);
    if (p_base[n] == bottom) begin
      p_link[n] = pool_hd; pool_hd = n;
      have = 0; mn = '0;
      for (s = inuse_hd; s != NIL; s = p_link[s])
        if (!have || p_base[s] < mn) begin
          mn = p_base[s]; have = 1;
        end
      s = freed_hd; prv = NIL;
      while (s != NIL) begin
        nx = p_link[s];
        if (!have || p_base[s] < mn) begin
          if (prv == NIL) freed_hd = p_link[s];
          else p_link[prv] = p_link[s];
          p_link[s] = pool_hd; pool_hd = s;
        end else prv = s;
        s = nx;
      end
      bottom = have ? mn : top_reg;
    end else begin
      p_link[n] = freed_hd; freed_hd = n;
    end
    return r;
  endfunction

  function automatic rsp_t predict_cmd(req_t r);
    case (r.mode)
      MODE_ALLOC: return predict_alloc(r.req_size);
      MODE_FREE:  return predict_free(r.slot_index);
      MODE_QUERY: return mk_rsp(ST_OK, r.slot_index, p_base[r.slot_index],
                                p_len[r.slot_index]);
      default:    return mk_rsp(ST_OK, r.slot_index, '0, '0);
    endcase
  endfunction

  function automatic req_t mk_req(logic [1:0] m, logic [ADDR_BITS-1:0] sz, logic [5:0] ix);
    req_t r;
    r.mode = m; r.req_size = sz; r.slot_index = ix;
    return r;
  endfunction

  function automatic int gap_draw();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // drive one command word; a typed expectation overrides the prediction
  task automatic send(req_t r, bit typed, rsp_t want);
    rsp_t p;
    int g;
    g = gap_draw();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall !== 1'b0);
    p = predict_cmd(r);
    pending_rsp.push_back(typed ? want : p);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [ADDR_BITS-1:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TOP) top_reg = val;
    else floor_reg = val;
  endtask

  // response side: random stalls, compare against the oldest expectation
  always begin
    rsp_t e;
    int g;
    if (rst) begin
      @(posedge clk);
    end else begin
      g = gap_draw();
      if (g > 0) begin
        rsp_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      if (pending_rsp.size() == 0) begin
        $error("response word with nothing expected: %p", rsp);
        fails++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp.status); fails++;
        end
        if (rsp.slot_out !== e.slot_out) begin
          $error("slot_out exp %0d got %0d", e.slot_out, rsp.slot_out); fails++;
        end
        if (rsp.base_addr !== e.base_addr) begin
          $error("base_addr exp %h got %h", e.base_addr, rsp.base_addr); fails++;
        end
        if (rsp.used_length !== e.used_length) begin
          $error("used_length exp %h got %h", e.used_length, rsp.used_length); fails++;
        end
      end
    end
  end

  // watchdog: cycles with no word accepted on either side
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("stream_buffer_allocator test failed");
      $finish;
    end
  end

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } vec_t;

  vec_t vecs [$];
  logic [ADDR_BITS-1:0] tops   [6] = '{24'hFFFFFF, 24'h002000, 24'hFFFFFF, 24'h000000,
                                       24'h000800, 24'h0};
  logic [ADDR_BITS-1:0] floors [6] = '{24'h0, 24'h000400, 24'hFFF000, 24'h0, 24'h000800,
                                       24'h0};

  initial begin
    int ix, pick, cnt, k;
    int busy_list [$];
    int wr_list [$];
    logic [ADDR_BITS-1:0] sz;
    rsp_t none;
    none = '0;
    predictor_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed commands at the reset configuration
    vecs = '{
      '{mk_req(MODE_ALLOC, 24'h0, 6'd0), 1, mk_rsp(ST_OK, 6'd0, 24'hFFFFFF, 24'h0)},
      '{mk_req(MODE_ALLOC, 24'h1, 6'd0), 1, mk_rsp(ST_OK, 6'd1, 24'hFFFFDF, 24'h20)},
      '{mk_req(MODE_ALLOC, 24'hFFFFFF, 6'd63), 1, mk_rsp(ST_FAIL, 6'd0, 24'h0, 24'h0)},
      '{mk_req(MODE_FREE, 24'h0, 6'd9), 1, mk_rsp(ST_UNUSED, 6'd9, 24'h0, 24'h0)},
      '{mk_req(MODE_NOP, 24'hFFFFFF, 6'd63), 1, mk_rsp(ST_OK, 6'd63, 24'h0, 24'h0)},
      '{mk_req(MODE_ALLOC, 24'd100, 6'd0), 0, none},
      '{mk_req(MODE_ALLOC, 24'hFFFFE0, 6'd0), 1, mk_rsp(ST_FAIL, 6'd0, 24'h0, 24'h0)},
      '{mk_req(MODE_FREE, 24'h0, 6'd0), 0, none},
      '{mk_req(MODE_FREE, 24'h0, 6'd1), 0, none},
      '{mk_req(MODE_ALLOC, 24'd32, 6'd0), 0, none},
      '{mk_req(MODE_ALLOC, 24'd1, 6'd0), 0, none},
      '{mk_req(MODE_ALLOC, 24'd0, 6'd0), 0, none},
      '{mk_req(MODE_QUERY, 24'h0, 6'd2), 0, none},
      '{mk_req(MODE_FREE, 24'h0, 6'd3), 0, none},
      '{mk_req(MODE_FREE, 24'h0, 6'd2), 0, none},
      '{mk_req(MODE_FREE, 24'h0, 6'd1), 0, none},
      '{mk_req(MODE_FREE, 24'h0, 6'd0), 0, none},
      '{mk_req(MODE_QUERY, 24'h0, 6'd0), 0, none},
      '{mk_req(MODE_FREE, 24'h0, 6'd0), 1, mk_rsp(ST_UNUSED, 6'd0, 24'h0, 24'h0)},
      '{mk_req(MODE_ALLOC, 24'h00003F, 6'd0), 0, none}
    };
    foreach (vecs[i]) send(vecs[i].r, vecs[i].typed, vecs[i].want);

    // random phases, each with its own region limits
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_TOP, ph == 5 ? ADDR_BITS'($urandom()) : tops[ph]);
      write_reg(REG_FLOOR, ph == 5 ? ADDR_BITS'($urandom_range(0, 24'h4000)) : floors[ph]);
      // release everything so the bottom returns to the new top
      busy_list = {};
      for (int s = 0; s < NSLOT; s++) if (p_busy[s]) busy_list.push_back(s);
      busy_list.shuffle();
      foreach (busy_list[i])
        send(mk_req(MODE_FREE, ADDR_BITS'($urandom()), 6'(busy_list[i])), 0, none);
      quiet = (ph == 2);
      for (cnt = 0; cnt < 260; cnt++) begin
        if (cnt % 90 == 89) begin
          quiet = !quiet;
          drain();
        end
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
          k = $urandom_range(0, 19);
          if (k == 0) sz = ADDR_BITS'($urandom());
          else if (k < 4) sz = ADDR_BITS'($urandom_range(0, 24'h1000));
          else sz = ADDR_BITS'($urandom_range(0, 16) * 32 - $urandom_range(0, 31));
          send(mk_req(MODE_ALLOC, sz, 6'($urandom())), 0, none);
        end else if (pick < 77) begin
          busy_list = {};
          for (int s = 0; s < NSLOT; s++) if (p_busy[s]) busy_list.push_back(s);
          if (busy_list.size() != 0 && $urandom_range(0, 4) != 0)
            ix = busy_list[$urandom_range(0, busy_list.size() - 1)];
          else ix = $urandom_range(0, 63);
          send(mk_req(MODE_FREE, ADDR_BITS'($urandom()), 6'(ix)), 0, none);
        end else if (pick < 95) begin
          wr_list = {};
          for (int s = 0; s < NSLOT; s++) if (p_written[s]) wr_list.push_back(s);
          if (wr_list.size() != 0)
            send(mk_req(MODE_QUERY, ADDR_BITS'($urandom()),
                        6'(wr_list[$urandom_range(0, wr_list.size() - 1)])), 0, none);
        end else begin
          send(mk_req(MODE_NOP, ADDR_BITS'($urandom()), 6'($urandom())), 0, none);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("stream_buffer_allocator test passed");
    else $display("stream_buffer_allocator test failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sba_pkg.sv
rtl/core/sba_ram.sv
rtl/core/sba_align.sv
rtl/core/stream_buffer_allocator.sv
tb/tb_stream_buffer_allocator.sv
